// ----- rtl/dca3_pkg.sv -----
// Shared constants, types and helper functions of the donor-cell advection block.
`timescale 1ns / 1ps
package dca3_pkg;

    localparam int GRID_CELLS = 6;
    localparam int EXT        = GRID_CELLS + 2;
    localparam int FACE       = GRID_CELLS + 3;
    localparam int FACE_DEPTH = FACE * FACE * FACE;
    localparam int CELL_DEPTH = EXT * EXT * EXT;
    localparam int FA_W       = $clog2(FACE_DEPTH);
    localparam int CA_W       = $clog2(CELL_DEPTH);
    localparam int POS_W      = 4;
    localparam int CW         = $clog2(EXT);
    localparam int Q_W        = 32;
    localparam int FLUX_W     = 6 * Q_W;

    // Steps of the per-cell flux sequence and the start of the advect loop
    localparam logic [4:0] ST_LATCH_HI   = 5'd1;
    localparam logic [4:0] ST_LATCH_LO   = 5'd2;
    localparam logic [4:0] ST_DISP_FIRST = 5'd3;
    localparam logic [4:0] ST_DISP_LAST  = 5'd8;
    localparam logic [4:0] ST_DLAT_FIRST = 5'd4;
    localparam logic [4:0] ST_DLAT_LAST  = 5'd9;
    localparam logic [4:0] ST_EXT        = 5'd10;
    localparam logic [4:0] ST_FLUX_FIRST = 5'd11;
    localparam logic [4:0] ST_FLUX_LAST  = 5'd22;
    localparam logic [4:0] ST_FLAT_FIRST = 5'd13;
    localparam logic [4:0] ST_FLAT_LAST  = 5'd23;
    localparam logic [4:0] ST_CELL_END   = 5'd24;
    localparam logic [4:0] ST_ADV_LOOP   = 5'd2;

    typedef enum logic [1:0] {
        CMD_VEL     = 2'd0,
        CMD_QTY     = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_ADVECT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_DX = 2'd0,
        REG_DY = 2'd1,
        REG_DZ = 2'd2,
        REG_TS = 2'd3
    } reg_idx_t;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    function automatic logic [FA_W-1:0] fidx(input logic [POS_W-1:0] x,
                                             input logic [POS_W-1:0] y,
                                             input logic [POS_W-1:0] z);
        int v;
        v = (int'(z) * FACE + int'(y)) * FACE + int'(x);
        return FA_W'(v);
    endfunction

    function automatic logic [CA_W-1:0] cidx(input logic [POS_W-1:0] x,
                                             input logic [POS_W-1:0] y,
                                             input logic [POS_W-1:0] z);
        int v;
        v = (int'(z) * EXT + int'(y)) * EXT + int'(x);
        return CA_W'(v);
    endfunction

    function automatic logic signed [Q_W-1:0] sat_wide(input logic signed [63:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = Q_MAX;
        else if (v < -64'sh0000_0000_8000_0000)
            r = Q_MIN;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/dca3_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module dca3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/donor_cell_advection_3d.sv -----
// Donor-cell advection: state memories, flux sequencer, advect sequencer, APB registers.
// Velocity and quantity writes are taken in their accept cycle; busy stays low.
// Compute: the cell volume first, then the fluxes of each extended cell in turn (EXT^3 cells),
// all through one shared 33x33 multiplier and one read port.
// Advect: one memory read and two products per neighbour; a rejected advect skips the loop.
// Result strobe done follows in the cycle after the last step and cannot be stalled.
// Reset (rst_n, asynchronous) restores the registers, clears busy and the flux-valid flag.
`timescale 1ns / 1ps
module donor_cell_advection_3d
    import dca3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           command,
    input  logic [POS_W-1:0]     pos_x,
    input  logic [POS_W-1:0]     pos_y,
    input  logic [POS_W-1:0]     pos_z,
    input  logic signed [31:0]   u_velocity,
    input  logic signed [31:0]   v_velocity,
    input  logic signed [31:0]   w_velocity,
    input  logic signed [31:0]   quantity,
    output logic                 done,
    output logic                 result_kind,
    output logic signed [31:0]   advected_value,
    output logic                 overflow_found,
    output logic [2:0]           overflow_x,
    output logic [2:0]           overflow_y,
    output logic [2:0]           overflow_z,
    output logic signed [31:0]   overflow_total,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_VOL  = 4'b0010,
        S_CELL = 4'b0100,
        S_ADV  = 4'b1000
    } state_t;

    // ---------------- configuration registers ----------------
    logic [30:0] dx_reg, dy_reg, dz_reg, ts_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg <= 31'd65536;
            dy_reg <= 31'd65536;
            dz_reg <= 31'd65536;
            ts_reg <= 31'd0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_DX:  dx_reg <= pwdata[30:0];
                REG_DY:  dy_reg <= pwdata[30:0];
                REG_DZ:  dz_reg <= pwdata[30:0];
                REG_TS:  ts_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_DX:  prdata = {1'b0, dx_reg};
            REG_DY:  prdata = {1'b0, dy_reg};
            REG_DZ:  prdata = {1'b0, dz_reg};
            REG_TS:  prdata = {1'b0, ts_reg};
            default: prdata = '0;
        endcase
    end

    // ---------------- memories ----------------
    logic              accept;
    logic              vel_we, qty_we, flux_we;
    logic [FA_W-1:0]   vel_waddr, u_raddr, v_raddr, w_raddr;
    logic [CA_W-1:0]   qty_waddr, cell_raddr, flux_waddr;
    logic [31:0]       u_rd, v_rd, w_rd, q_rd;
    logic [FLUX_W-1:0] f_rd, flux_wdata;

    assign accept    = start && !busy;
    assign vel_we    = accept && (cmd_t'(command) == CMD_VEL) && (pos_x < POS_W'(FACE))
                       && (pos_y < POS_W'(FACE)) && (pos_z < POS_W'(FACE));
    assign qty_we    = accept && (cmd_t'(command) == CMD_QTY) && (pos_x < POS_W'(EXT))
                       && (pos_y < POS_W'(EXT)) && (pos_z < POS_W'(EXT));
    assign vel_waddr = fidx(pos_x, pos_y, pos_z);
    assign qty_waddr = cidx(pos_x, pos_y, pos_z);

    dca3_ram #(.WIDTH(32), .DEPTH(FACE_DEPTH)) u_mem (
        .clk(clk), .we(vel_we), .waddr(vel_waddr), .wdata(u_velocity),
        .raddr(u_raddr), .rdata(u_rd));
    dca3_ram #(.WIDTH(32), .DEPTH(FACE_DEPTH)) v_mem (
        .clk(clk), .we(vel_we), .waddr(vel_waddr), .wdata(v_velocity),
        .raddr(v_raddr), .rdata(v_rd));
    dca3_ram #(.WIDTH(32), .DEPTH(FACE_DEPTH)) w_mem (
        .clk(clk), .we(vel_we), .waddr(vel_waddr), .wdata(w_velocity),
        .raddr(w_raddr), .rdata(w_rd));
    dca3_ram #(.WIDTH(32), .DEPTH(CELL_DEPTH)) q_mem (
        .clk(clk), .we(qty_we), .waddr(qty_waddr), .wdata(quantity),
        .raddr(cell_raddr), .rdata(q_rd));
    dca3_ram #(.WIDTH(FLUX_W), .DEPTH(CELL_DEPTH)) f_mem (
        .clk(clk), .we(flux_we), .waddr(flux_waddr), .wdata(flux_wdata),
        .raddr(cell_raddr), .rdata(f_rd));

    // ---------------- shared multiplier ----------------
    logic signed [32:0]     mul_a, mul_b;
    logic signed [65:0]     prod_reg;
    logic signed [Q_W-1:0]  qm;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // floor shift then saturate
    assign qm = sat_wide(64'(prod_reg >>> 16));

    // ---------------- control and datapath state ----------------
    state_t          state_reg, state_next;
    logic [4:0]      step_reg, step_next;
    logic            fvalid_reg, fvalid_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;

    logic [POS_W-1:0]      ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [Q_W-1:0] vol_reg, vol_next;
    logic signed [Q_W-1:0] vel_reg [6];
    logic signed [Q_W-1:0] vel_next [6];
    logic signed [Q_W-1:0] disp_reg [6];
    logic signed [Q_W-1:0] disp_next [6];
    logic signed [Q_W-1:0] ext_reg [3];
    logic signed [Q_W-1:0] ext_next [3];
    logic signed [Q_W-1:0] flux_reg [6];
    logic signed [Q_W-1:0] flux_next [6];
    logic signed [Q_W-1:0] qc_reg, qc_next;
    logic [FLUX_W-1:0]     fc_reg, fc_next;
    logic signed [35:0]    acc_reg, acc_next;
    logic                  found_reg, found_next;
    logic [CW-1:0]         ex_reg, ex_next, ey_reg, ey_next, ez_reg, ez_next;
    logic signed [Q_W-1:0] etot_reg, etot_next;

    logic                  kind_reg, kind_next;
    logic signed [Q_W-1:0] advv_reg, advv_next;
    logic                  ofound_reg, ofound_next;
    logic [2:0]            ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic signed [Q_W-1:0] otot_reg, otot_next;

    // combinational helpers
    logic [POS_W-1:0]      px, py, pz, nx, ny, nz;
    logic [4:0]            t_flux, t_adv;
    logic [2:0]            fj, dk, ak;
    logic [1:0]            aph;
    logic signed [63:0]    ext_x_w, ext_y_w, ext_z_w, sum_w;
    logic signed [Q_W-1:0] tot;
    logic                  last_cell, interior;

    function automatic logic [1:0] ext_a_sel(input logic [2:0] j);
        return (j == 3'd2 || j == 3'd3) ? 2'd1 : 2'd0;
    endfunction

    function automatic logic [1:0] ext_b_sel(input logic [2:0] j);
        return (j == 3'd4 || j == 3'd5) ? 2'd1 : 2'd2;
    endfunction

    assign px = POS_W'(cx_reg);
    assign py = POS_W'(cy_reg);
    assign pz = POS_W'(cz_reg);

    assign t_flux = step_reg - ST_FLUX_FIRST;
    assign t_adv  = step_reg - ST_ADV_LOOP;
    assign fj     = t_flux[3:1];
    assign ak     = t_adv[4:2];
    assign aph    = t_adv[1:0];
    assign dk     = 3'(step_reg - ST_DLAT_FIRST);

    assign interior = (pos_x >= POS_W'(1)) && (pos_x <= POS_W'(GRID_CELLS))
                   && (pos_y >= POS_W'(1)) && (pos_y <= POS_W'(GRID_CELLS))
                   && (pos_z >= POS_W'(1)) && (pos_z <= POS_W'(GRID_CELLS));

    assign last_cell = (cx_reg == CW'(EXT - 1)) && (cy_reg == CW'(EXT - 1))
                    && (cz_reg == CW'(EXT - 1));

    // neighbour of the advected cell in direction ak
    always_comb
    begin
        nx = ax_reg;
        ny = ay_reg;
        nz = az_reg;
        case (ak)
            3'd0:    ny = ay_reg + POS_W'(1);
            3'd1:    ny = ay_reg - POS_W'(1);
            3'd2:    nx = ax_reg + POS_W'(1);
            3'd3:    nx = ax_reg - POS_W'(1);
            3'd4:    nz = az_reg + POS_W'(1);
            3'd5:    nz = az_reg - POS_W'(1);
            default: ;
        endcase
    end

    assign ext_x_w = 64'(signed'({1'b0, dx_reg})) - 64'(disp_reg[2]) - 64'(disp_reg[3]);
    assign ext_y_w = 64'(signed'({1'b0, dy_reg})) - 64'(disp_reg[0]) - 64'(disp_reg[1]);
    assign ext_z_w = 64'(signed'({1'b0, dz_reg})) - 64'(disp_reg[4]) - 64'(disp_reg[5]);
    assign sum_w   = 64'(flux_reg[0]) + 64'(flux_reg[1]) + 64'(flux_reg[2])
                   + 64'(flux_reg[3]) + 64'(flux_reg[4]) + 64'(flux_reg[5]);
    assign tot     = sat_wide(sum_w);

    assign flux_waddr = cidx(px, py, pz);
    assign flux_wdata = {flux_reg[5], flux_reg[4], flux_reg[3],
                         flux_reg[2], flux_reg[1], flux_reg[0]};

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        fvalid_next = fvalid_reg;
        done_next   = 1'b0;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cz_next     = cz_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        az_next     = az_reg;
        vol_next    = vol_reg;
        vel_next    = vel_reg;
        disp_next   = disp_reg;
        ext_next    = ext_reg;
        flux_next   = flux_reg;
        qc_next     = qc_reg;
        fc_next     = fc_reg;
        acc_next    = acc_reg;
        found_next  = found_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        ez_next     = ez_reg;
        etot_next   = etot_reg;
        kind_next   = kind_reg;
        advv_next   = advv_reg;
        ofound_next = ofound_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oz_next     = oz_reg;
        otot_next   = otot_reg;
        mul_a       = '0;
        mul_b       = '0;
        flux_we     = 1'b0;
        u_raddr     = fidx(px, py, pz);
        v_raddr     = fidx(px, py, pz);
        w_raddr     = fidx(px, py, pz);
        cell_raddr  = cidx(ax_reg, ay_reg, az_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(command))
                        CMD_COMPUTE:
                        begin
                            state_next = S_VOL;
                            step_next  = '0;
                            found_next = 1'b0;
                            ex_next    = '0;
                            ey_next    = '0;
                            ez_next    = '0;
                            etot_next  = '0;
                            cx_next    = '0;
                            cy_next    = '0;
                            cz_next    = '0;
                        end
                        CMD_ADVECT:
                        begin
                            ax_next  = pos_x;
                            ay_next  = pos_y;
                            az_next  = pos_z;
                            acc_next = '0;
                            if (fvalid_reg && interior)
                            begin
                                state_next = S_ADV;
                                step_next  = '0;
                            end
                            else
                            begin
                                // rejected advect reports zero at once
                                done_next   = 1'b1;
                                kind_next   = 1'b1;
                                advv_next   = '0;
                                ofound_next = 1'b0;
                                ox_next     = '0;
                                oy_next     = '0;
                                oz_next     = '0;
                                otot_next   = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_VOL:
            begin
                step_next = step_reg + 5'd1;
                case (step_reg)
                    5'd0:
                    begin
                        mul_a = 33'(signed'({1'b0, dx_reg}));
                        mul_b = 33'(signed'({1'b0, dy_reg}));
                    end
                    5'd1:
                    begin
                        mul_a = 33'(qm);
                        mul_b = 33'(signed'({1'b0, dz_reg}));
                    end
                    default:
                    begin
                        vol_next   = qm;
                        state_next = S_CELL;
                        step_next  = '0;
                    end
                endcase
            end

            S_CELL:
            begin
                step_next = step_reg + 5'd1;
                // high faces first, low faces in the next cycle
                if (step_reg == 5'd0)
                begin
                    u_raddr = fidx(px + POS_W'(1), py, pz);
                    v_raddr = fidx(px, py + POS_W'(1), pz);
                    w_raddr = fidx(px, py, pz + POS_W'(1));
                end
                if (step_reg == ST_LATCH_HI)
                begin
                    vel_next[2] = u_rd;
                    vel_next[0] = v_rd;
                    vel_next[4] = w_rd;
                end
                if (step_reg == ST_LATCH_LO)
                begin
                    vel_next[3] = u_rd;
                    vel_next[1] = v_rd;
                    vel_next[5] = w_rd;
                end
                if (step_reg >= ST_DISP_FIRST && step_reg <= ST_DISP_LAST)
                begin
                    mul_a = 33'(vel_reg[3'(step_reg - ST_DISP_FIRST)]);
                    mul_b = 33'(signed'({1'b0, ts_reg}));
                end
                if (step_reg >= ST_DLAT_FIRST && step_reg <= ST_DLAT_LAST)
                begin
                    if (!dk[0])
                        disp_next[dk] = qm[Q_W-1] ? '0 : qm;
                    else if (!qm[Q_W-1])
                        disp_next[dk] = '0;
                    else if (qm == Q_MIN)
                        disp_next[dk] = Q_MAX;
                    else
                        disp_next[dk] = -qm;
                end
                if (step_reg == ST_EXT)
                begin
                    ext_next[0] = sat_wide(ext_x_w);
                    ext_next[1] = sat_wide(ext_y_w);
                    ext_next[2] = sat_wide(ext_z_w);
                end
                if (step_reg >= ST_FLUX_FIRST && step_reg <= ST_FLUX_LAST)
                begin
                    if (!t_flux[0])
                    begin
                        mul_a = 33'(disp_reg[fj]);
                        mul_b = 33'(ext_reg[ext_a_sel(fj)]);
                    end
                    else
                    begin
                        mul_a = 33'(qm);
                        mul_b = 33'(ext_reg[ext_b_sel(fj)]);
                    end
                end
                if (step_reg >= ST_FLAT_FIRST && step_reg <= ST_FLAT_LAST && step_reg[0])
                begin
                    flux_next[3'((step_reg - ST_FLAT_FIRST) >> 1)] = qm;
                end
                if (step_reg == ST_CELL_END)
                begin
                    flux_we   = 1'b1;
                    step_next = '0;
                    if (tot > vol_reg)
                    begin
                        found_next = 1'b1;
                        ex_next    = cx_reg;
                        ey_next    = cy_reg;
                        ez_next    = cz_reg;
                        etot_next  = tot;
                    end
                    // advance x fastest, z slowest
                    if (cx_reg == CW'(EXT - 1))
                    begin
                        cx_next = '0;
                        if (cy_reg == CW'(EXT - 1))
                        begin
                            cy_next = '0;
                            cz_next = cz_reg + CW'(1);
                        end
                        else
                        begin
                            cy_next = cy_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        cx_next = cx_reg + CW'(1);
                    end
                    if (last_cell)
                    begin
                        state_next  = S_IDLE;
                        fvalid_next = 1'b1;
                        done_next   = 1'b1;
                        kind_next   = 1'b0;
                        advv_next   = '0;
                        ofound_next = found_next;
                        ox_next     = 3'(ex_next);
                        oy_next     = 3'(ey_next);
                        oz_next     = 3'(ez_next);
                        otot_next   = etot_next;
                    end
                end
            end

            S_ADV:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd0)
                begin
                    cell_raddr = cidx(ax_reg, ay_reg, az_reg);
                end
                else if (step_reg == 5'd1)
                begin
                    qc_next = q_rd;
                    fc_next = f_rd;
                end
                else
                begin
                    cell_raddr = cidx(nx, ny, nz);
                    case (aph)
                        2'd1:
                        begin
                            mul_a = 33'(signed'(q_rd));
                            mul_b = 33'(signed'(f_rd[Q_W * int'(ak ^ 3'd1) +: Q_W]));
                        end
                        2'd2:
                        begin
                            acc_next = acc_reg + 36'(qm);
                            mul_a    = 33'(qc_reg);
                            mul_b    = 33'(signed'(fc_reg[Q_W * int'(ak) +: Q_W]));
                        end
                        2'd3:
                        begin
                            acc_next = acc_reg - 36'(qm);
                            if (ak == 3'd5)
                            begin
                                state_next  = S_IDLE;
                                done_next   = 1'b1;
                                kind_next   = 1'b1;
                                advv_next   = sat_wide(64'(acc_next));
                                ofound_next = 1'b0;
                                ox_next     = '0;
                                oy_next     = '0;
                                oz_next     = '0;
                                otot_next   = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            fvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            fvalid_reg <= fvalid_next;
            done_reg   <= done_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            cz_reg     <= cz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        az_reg     <= az_next;
        vol_reg    <= vol_next;
        vel_reg    <= vel_next;
        disp_reg   <= disp_next;
        ext_reg    <= ext_next;
        flux_reg   <= flux_next;
        qc_reg     <= qc_next;
        fc_reg     <= fc_next;
        acc_reg    <= acc_next;
        found_reg  <= found_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        ez_reg     <= ez_next;
        etot_reg   <= etot_next;
        kind_reg   <= kind_next;
        advv_reg   <= advv_next;
        ofound_reg <= ofound_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oz_reg     <= oz_next;
        otot_reg   <= otot_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign result_kind    = kind_reg;
    assign advected_value = advv_reg;
    assign overflow_found = ofound_reg;
    assign overflow_x     = ox_reg;
    assign overflow_y     = oy_reg;
    assign overflow_z     = oz_reg;
    assign overflow_total = otot_reg;

endmodule

// ----- tb/sv/donor_cell_advection_3d_test.sv -----
// Self-checking testbench of the donor-cell advection block with a built-in predictor.
`timescale 1ns / 1ps
module donor_cell_advection_3d_test;
    import dca3_pkg::*;

    typedef struct {
        logic        kind;
        logic [31:0] value;
        logic        found;
        logic [2:0]  ox;
        logic [2:0]  oy;
        logic [2:0]  oz;
        logic [31:0] total;
    } advect_result_t;

    class advect_predictor;
        longint         dx, dy, dz, ts;
        int             u_mem[FACE_DEPTH];
        int             v_mem[FACE_DEPTH];
        int             w_mem[FACE_DEPTH];
        int             q_mem[CELL_DEPTH];
        int             flux_mem[CELL_DEPTH][6];
        bit             flux_ready;
        advect_result_t pending_results[$];
        int             fails;

        function new();
            dx = 65536;
            dy = 65536;
            dz = 65536;
            ts = 0;
            flux_ready = 0;
            fails = 0;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // floor shift of the exact product, then saturate
        function longint qmul(longint a, longint b);
            longint p;
            p = a * b;
            return sat(p >>> 16);
        endfunction

        function longint clamp0(longint v);
            return (v < 0) ? 0 : v;
        endfunction

        function int fi(int x, int y, int z);
            return (z * FACE + y) * FACE + x;
        endfunction

        function int ci(int x, int y, int z);
            return (z * EXT + y) * EXT + x;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] data);
            longint v;
            v = longint'(data[30:0]);
            case (idx)
                REG_DX: dx = v;
                REG_DY: dy = v;
                REG_DZ: dz = v;
                REG_TS: ts = v;
            endcase
        endfunction

        function advect_result_t compute_fluxes();
            advect_result_t r;
            longint         vol, top, bot, rgt, lft, frt, bck, ex, ey, ez, sum, tot;
            int             c;
            r = '{1'b0, 32'd0, 1'b0, 3'd0, 3'd0, 3'd0, 32'd0};
            vol = qmul(qmul(dx, dy), dz);
            for (int z = 0; z < EXT; z++)
                for (int y = 0; y < EXT; y++)
                    for (int x = 0; x < EXT; x++)
                    begin
                        top = clamp0(qmul(v_mem[fi(x, y + 1, z)], ts));
                        bot = clamp0(sat(-qmul(v_mem[fi(x, y, z)], ts)));
                        rgt = clamp0(qmul(u_mem[fi(x + 1, y, z)], ts));
                        lft = clamp0(sat(-qmul(u_mem[fi(x, y, z)], ts)));
                        frt = clamp0(qmul(w_mem[fi(x, y, z + 1)], ts));
                        bck = clamp0(sat(-qmul(w_mem[fi(x, y, z)], ts)));
                        ex = sat(dx - rgt - lft);
                        ey = sat(dy - top - bot);
                        ez = sat(dz - frt - bck);
                        c = ci(x, y, z);
                        flux_mem[c][0] = int'(qmul(qmul(top, ex), ez));
                        flux_mem[c][1] = int'(qmul(qmul(bot, ex), ez));
                        flux_mem[c][2] = int'(qmul(qmul(rgt, ey), ez));
                        flux_mem[c][3] = int'(qmul(qmul(lft, ey), ez));
                        flux_mem[c][4] = int'(qmul(qmul(frt, ex), ey));
                        flux_mem[c][5] = int'(qmul(qmul(bck, ex), ey));
                        sum = 0;
                        for (int k = 0; k < 6; k++)
                            sum += flux_mem[c][k];
                        tot = sat(sum);
                        if (tot > vol)
                        begin
                            r.found = 1'b1;
                            r.ox = 3'(x);
                            r.oy = 3'(y);
                            r.oz = 3'(z);
                            r.total = 32'(tot);
                        end
                    end
            flux_ready = 1;
            return r;
        endfunction

        function longint advect_cell(int x, int y, int z);
            int     sx[6] = '{0, 0, 1, -1, 0, 0};
            int     sy[6] = '{1, -1, 0, 0, 0, 0};
            int     sz[6] = '{0, 0, 0, 0, 1, -1};
            int     opp[6] = '{1, 0, 3, 2, 5, 4};
            int     c, n;
            longint acc;
            if (!flux_ready)
                return 0;
            if (x < 1 || x > GRID_CELLS || y < 1 || y > GRID_CELLS
                || z < 1 || z > GRID_CELLS)
                return 0;
            c = ci(x, y, z);
            acc = 0;
            for (int k = 0; k < 6; k++)
            begin
                n = ci(x + sx[k], y + sy[k], z + sz[k]);
                acc -= qmul(q_mem[c], flux_mem[c][k]);
                acc += qmul(q_mem[n], flux_mem[n][opp[k]]);
            end
            return sat(acc);
        endfunction

        function void note_item(cmd_t cmd, int x, int y, int z,
                                int u, int v, int w, int q);
            advect_result_t r;
            case (cmd)
                CMD_VEL:
                    if (x < FACE && y < FACE && z < FACE)
                    begin
                        u_mem[fi(x, y, z)] = u;
                        v_mem[fi(x, y, z)] = v;
                        w_mem[fi(x, y, z)] = w;
                    end
                CMD_QTY:
                    if (x < EXT && y < EXT && z < EXT)
                        q_mem[ci(x, y, z)] = q;
                CMD_COMPUTE:
                    pending_results.push_back(compute_fluxes());
                CMD_ADVECT:
                begin
                    r = '{1'b1, 32'(advect_cell(x, y, z)), 1'b0, 3'd0, 3'd0, 3'd0, 32'd0};
                    pending_results.push_back(r);
                end
            endcase
        endfunction

        function void check_result(advect_result_t got);
            advect_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: kind %0d value %h", got.kind, got.value);
                fails++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.kind !== exp_r.kind)
            begin
                $error("result_kind: expected %0d, got %0d", exp_r.kind, got.kind);
                fails++;
            end
            if (got.value !== exp_r.value)
            begin
                $error("advected_value: expected %h, got %h", exp_r.value, got.value);
                fails++;
            end
            if (got.found !== exp_r.found)
            begin
                $error("overflow_found: expected %0d, got %0d", exp_r.found, got.found);
                fails++;
            end
            if (got.ox !== exp_r.ox)
            begin
                $error("overflow_x: expected %0d, got %0d", exp_r.ox, got.ox);
                fails++;
            end
            if (got.oy !== exp_r.oy)
            begin
                $error("overflow_y: expected %0d, got %0d", exp_r.oy, got.oy);
                fails++;
            end
            if (got.oz !== exp_r.oz)
            begin
                $error("overflow_z: expected %0d, got %0d", exp_r.oz, got.oz);
                fails++;
            end
            if (got.total !== exp_r.total)
            begin
                $error("overflow_total: expected %h, got %h", exp_r.total, got.total);
                fails++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         command = CMD_VEL;
    logic [POS_W-1:0]   pos_x = '0;
    logic [POS_W-1:0]   pos_y = '0;
    logic [POS_W-1:0]   pos_z = '0;
    logic signed [31:0] u_velocity = '0;
    logic signed [31:0] v_velocity = '0;
    logic signed [31:0] w_velocity = '0;
    logic signed [31:0] quantity = '0;
    logic               done;
    logic               result_kind;
    logic signed [31:0] advected_value;
    logic               overflow_found;
    logic [2:0]         overflow_x;
    logic [2:0]         overflow_y;
    logic [2:0]         overflow_z;
    logic signed [31:0] overflow_total;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    advect_predictor model = new();

    donor_cell_advection_3d u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .u_velocity     (u_velocity),
        .v_velocity     (v_velocity),
        .w_velocity     (w_velocity),
        .quantity       (quantity),
        .done           (done),
        .result_kind    (result_kind),
        .advected_value (advected_value),
        .overflow_found (overflow_found),
        .overflow_x     (overflow_x),
        .overflow_y     (overflow_y),
        .overflow_z     (overflow_z),
        .overflow_total (overflow_total),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            model.check_result('{result_kind, advected_value, overflow_found,
                                 overflow_x, overflow_y, overflow_z, overflow_total});
    end

    // Mostly small values so that displacements land near the cell size
    function automatic int pick_q();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 0;
            3, 4: return int'($urandom);
            default: return int'($urandom_range(0, 262144)) - 131072;
        endcase
    endfunction

    task automatic send_item(cmd_t cmd, int x, int y, int z, int u, int v, int w, int q);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        pos_x <= POS_W'(x);
        pos_y <= POS_W'(y);
        pos_z <= POS_W'(z);
        u_velocity <= u;
        v_velocity <= v;
        w_velocity <= w;
        quantity <= q;
        do
            @(posedge clk);
        while (busy);
        model.note_item(cmd, x, y, z, u, v, w, q);
    endtask

    // Drain all pending transactions, leave the block idle, then write a register
    task automatic write_register(reg_idx_t idx, logic [31:0] data);
        start <= 1'b0;
        while (model.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model.set_register(idx, data);
    endtask

    task automatic set_geometry(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                logic [31:0] ts);
        write_register(REG_DX, dx);
        write_register(REG_DY, dy);
        write_register(REG_DZ, dz);
        write_register(REG_TS, ts);
    endtask

    task automatic random_item();
        int sel, x, y, z;
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                x = $urandom_range(0, 15);
                y = $urandom_range(0, 15);
                z = $urandom_range(0, 15);
            end
            else
            begin
                x = $urandom_range(1, GRID_CELLS);
                y = $urandom_range(1, GRID_CELLS);
                z = $urandom_range(1, GRID_CELLS);
            end
            send_item(CMD_ADVECT, x, y, z, pick_q(), pick_q(), pick_q(), pick_q());
        end
        else if (sel < 8)
        begin
            x = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(0, FACE - 1);
            y = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(0, FACE - 1);
            z = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(0, FACE - 1);
            send_item(CMD_VEL, x, y, z, pick_q(), pick_q(), pick_q(), pick_q());
        end
        else
        begin
            x = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(0, EXT - 1);
            y = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(0, EXT - 1);
            z = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(0, EXT - 1);
            send_item(CMD_QTY, x, y, z, pick_q(), pick_q(), pick_q(), pick_q());
        end
    endtask

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [31:0] geo[10][4];
        geo = '{
            '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000},
            '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_4000},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000},
            '{32'h0000_8000, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000},
            '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_2000},
            '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000},
            '{$urandom, $urandom, $urandom, $urandom},
            '{$urandom_range(0, 32'h4_0000), $urandom_range(0, 32'h4_0000),
              $urandom_range(0, 32'h4_0000), $urandom_range(0, 32'h2_0000)},
            '{$urandom_range(0, 32'h4_0000), $urandom_range(0, 32'h4_0000),
              $urandom_range(0, 32'h4_0000), $urandom_range(0, 32'h2_0000)}
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // advect before any compute, then ignored out-of-range writes
        send_item(CMD_ADVECT, 3, 3, 3, 0, 0, 0, 0);
        send_item(CMD_VEL, FACE, 0, 0, -1, -1, -1, -1);
        send_item(CMD_VEL, 15, 15, 15, -1, -1, -1, -1);
        send_item(CMD_QTY, EXT, 2, 2, -1, -1, -1, -1);
        send_item(CMD_QTY, 15, 15, 15, -1, -1, -1, -1);

        // fill every velocity face and every quantity cell before anything reads them
        for (int z = 0; z < FACE; z++)
            for (int y = 0; y < FACE; y++)
                for (int x = 0; x < FACE; x++)
                    send_item(CMD_VEL, x, y, z, pick_q(), pick_q(), pick_q(), pick_q());
        for (int z = 0; z < EXT; z++)
            for (int y = 0; y < EXT; y++)
                for (int x = 0; x < EXT; x++)
                    send_item(CMD_QTY, x, y, z, pick_q(), pick_q(), pick_q(), pick_q());

        for (int p = 0; p < 10; p++)
        begin
            set_geometry(geo[p][0], geo[p][1], geo[p][2], geo[p][3]);
            send_item(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0);
            send_item(CMD_ADVECT, 1, 1, 1, 0, 0, 0, 0);
            send_item(CMD_ADVECT, GRID_CELLS, GRID_CELLS, GRID_CELLS, 0, 0, 0, 0);
            send_item(CMD_ADVECT, 0, 3, 3, 0, 0, 0, 0);
            send_item(CMD_ADVECT, 3, GRID_CELLS + 1, 3, 0, 0, 0, 0);
            // later writes must leave the stored fluxes stale until the next compute
            repeat (3) random_item();
            send_item(CMD_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 15), 0, 0, 0, 0);
            repeat (1) random_item();
        end

        start <= 1'b0;
        while (model.pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (model.fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
